// File: design/sentinel_packet_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// The enclosing module must provide clk and rst_n.
`ifndef SENTINEL_PACKET_DEFRAMER_ASSERT_SVH
`define SENTINEL_PACKET_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
`define SPD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPD_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: design/spd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

  localparam int unsigned MAX_PATTERN_BYTES = 8;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic ITEM_DATA = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  localparam logic [1:0] CAUSE_TAIL    = 2'd0;
  localparam logic [1:0] CAUSE_LENGTH  = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

  localparam logic [2:0] REG_HEAD     = 3'd0;
  localparam logic [2:0] REG_TAIL     = 3'd1;
  localparam logic [2:0] REG_PAT_LEN  = 3'd2;
  localparam logic [2:0] REG_USE_HEAD = 3'd3;
  localparam logic [2:0] REG_USE_TAIL = 3'd4;
  localparam logic [2:0] REG_MAX_LEN  = 3'd5;
  localparam logic [2:0] REG_TIMEOUT  = 3'd6;

  typedef struct packed {
    logic [63:0] head;
    logic [63:0] tail;
    logic [3:0]  pat_len;
    logic        use_head;
    logic        use_tail;
    logic [15:0] max_len;
    logic [23:0] timeout;
  } cfg_t;

  // Results caused by one request: up to eight data bytes, then an optional end item.
  typedef struct packed {
    logic        valid;
    logic [63:0] data;
    logic [3:0]  n_data;
    logic        has_end;
    logic [1:0]  cause;
    logic [15:0] count;
  } bundle_t;

endpackage
`default_nettype wire

// File: design/spd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: design/spd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spd_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  data_byte;
  logic [1:0]  end_cause;
  logic [15:0] byte_count;
  logic        last;

  modport source (output valid, output item_kind, output data_byte, output end_cause,
                  output byte_count, output last, input ready);
  modport sink (input valid, input item_kind, input data_byte, input end_cause,
                input byte_count, input last, output ready);
endinterface
`default_nettype wire

// File: design/spd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// File: design/sentinel_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Port    Dir  Contents
// input    in_ch   in   command, rx_byte
// result   out_ch  out  item_kind, data_byte, end_cause, byte_count, last
// config   cfg_ch  in   index, wdata (register write, always ready)
//
// One request is taken per cycle when its results fit behind the result register.
// A request that causes several results stalls the input while they drain;
// the next request is taken in the cycle the last of them is taken.
// Results appear in the cycle after their request; a stalled result holds its fields.
// Reset (rst_n low at a clock edge) clears the packet state and loads register defaults.
module sentinel_packet_deframer (
  input  logic      clk,
  input  logic      rst_n,
  spd_in_if.sink    in_ch,
  spd_out_if.source out_ch,
  spd_cfg_if.sink   cfg_ch
);

  spd_pkg::cfg_t    cfg;
  spd_pkg::bundle_t bundle;
  logic             take;

  spd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  spd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .take   (take),
    .in_ch  (in_ch),
    .bundle (bundle)
  );

  spd_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .bundle (bundle),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// File: design/spd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module spd_cfg (
  input  logic          clk,
  input  logic          rst_n,
  spd_cfg_if.sink       cfg_ch,
  output spd_pkg::cfg_t cfg
);

  spd_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head     <= 64'd0;
      cfg_r.tail     <= 64'd0;
      cfg_r.pat_len  <= 4'd1;
      cfg_r.use_head <= 1'b0;
      cfg_r.use_tail <= 1'b0;
      cfg_r.max_len  <= 16'hFFFF;
      cfg_r.timeout  <= 24'd1000;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        spd_pkg::REG_HEAD:     cfg_r.head     <= cfg_ch.wdata;
        spd_pkg::REG_TAIL:     cfg_r.tail     <= cfg_ch.wdata;
        spd_pkg::REG_PAT_LEN:  cfg_r.pat_len  <= cfg_ch.wdata[3:0];
        spd_pkg::REG_USE_HEAD: cfg_r.use_head <= cfg_ch.wdata[0];
        spd_pkg::REG_USE_TAIL: cfg_r.use_tail <= cfg_ch.wdata[0];
        spd_pkg::REG_MAX_LEN:  cfg_r.max_len  <= cfg_ch.wdata[15:0];
        spd_pkg::REG_TIMEOUT:  cfg_r.timeout  <= cfg_ch.wdata[23:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/spd_core.sv
`timescale 1ns / 1ps
`default_nettype none
module spd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  spd_pkg::cfg_t    cfg,
  input  logic             take,
  spd_in_if.sink           in_ch,
  output spd_pkg::bundle_t bundle
);

  localparam logic [3:0] MAX_PAT = 4'(spd_pkg::MAX_PATTERN_BYTES);

  // Last k bytes of the history, oldest in bits 7:0.
  function automatic logic [63:0] win_bytes(input logic [63:0] v, input logic [3:0] k);
    logic [6:0] sh;
    sh = {4'd8 - k, 3'b000};
    return v >> sh;
  endfunction

  logic [63:0] recent_r, recent_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        head_seen_r, head_seen_nxt;
  logic        recv_r, recv_nxt;
  logic [23:0] idle_r, idle_nxt;

  logic        acc;
  logic [3:0]  n;
  logic [63:0] recent_sh, win_n;
  logic [15:0] cnt_inc;
  logic [23:0] idle_inc;
  logic        hunting, head_eq, tail_eq, check_tail;
  logic        fire_end;
  logic [1:0]  cause;
  logic [3:0]  k_path, k;

  assign in_ch.ready = take;
  assign acc         = in_ch.valid && take;

  always_comb begin
    if (cfg.pat_len == 4'd0)        n = 4'd1;
    else if (cfg.pat_len > MAX_PAT) n = MAX_PAT;
    else                            n = cfg.pat_len;
  end

  assign recent_sh = {in_ch.rx_byte, recent_r[63:8]};
  assign cnt_inc   = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
  assign idle_inc  = (idle_r == 24'hFFFFFF) ? idle_r : idle_r + 24'd1;
  assign hunting   = cfg.use_head && !head_seen_r;
  assign win_n     = win_bytes(recent_sh, n);

  always_comb begin
    head_eq = 1'b1;
    tail_eq = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) begin
        if (win_n[8*i +: 8] != cfg.head[8*i +: 8]) head_eq = 1'b0;
        if (win_n[8*i +: 8] != cfg.tail[8*i +: 8]) tail_eq = 1'b0;
      end
    end
  end

  always_comb begin
    recent_nxt    = recent_r;
    cnt_nxt       = cnt_r;
    head_seen_nxt = head_seen_r;
    recv_nxt      = recv_r;
    idle_nxt      = idle_r;
    fire_end      = 1'b0;
    cause         = spd_pkg::CAUSE_TAIL;
    k_path        = 4'd0;
    check_tail    = 1'b0;

    case (in_ch.command)
      spd_pkg::CMD_START: begin
        recent_nxt    = 64'd0;
        cnt_nxt       = 16'd0;
        head_seen_nxt = 1'b0;
        idle_nxt      = 24'd0;
        recv_nxt      = 1'b1;
        if (cfg.max_len == 16'd0) begin
          fire_end = 1'b1;
          cause    = spd_pkg::CAUSE_LENGTH;
        end
      end
      spd_pkg::CMD_BYTE: begin
        if (recv_r) begin
          idle_nxt   = 24'd0;
          recent_nxt = recent_sh;
          cnt_nxt    = cnt_inc;
          check_tail = 1'b1;
          if (hunting) begin
            check_tail = 1'b0;
            if (cnt_inc >= {12'd0, n}) begin
              if (head_eq) begin
                head_seen_nxt = 1'b1;
                check_tail    = 1'b1;
                k_path        = (cnt_inc < 16'd8) ? cnt_inc[3:0] : n;
              end else begin
                // drop the held bytes and hunt again
                cnt_nxt    = 16'd0;
                recent_nxt = 64'd0;
              end
            end
          end else begin
            k_path = 4'd1;
          end
          if (check_tail && cfg.use_tail && cnt_inc >= {12'd0, n} && tail_eq) begin
            fire_end = 1'b1;
            cause    = spd_pkg::CAUSE_TAIL;
          end else if (cnt_nxt >= cfg.max_len) begin
            fire_end = 1'b1;
            cause    = spd_pkg::CAUSE_LENGTH;
          end
        end
      end
      spd_pkg::CMD_TICK: begin
        if (recv_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= cfg.timeout) begin
            fire_end = 1'b1;
            cause    = spd_pkg::CAUSE_TIMEOUT;
          end
        end
      end
      default: ;
    endcase

    k = k_path;
    if (fire_end) begin
      recv_nxt = 1'b0;
      // flush bytes still held for the head check
      if (cfg.use_head && !head_seen_nxt && cnt_nxt < 16'd8) k = cnt_nxt[3:0];
    end
  end

  always_comb begin
    bundle.valid   = acc && (fire_end || k != 4'd0);
    bundle.data    = win_bytes(recent_nxt, k);
    bundle.n_data  = k;
    bundle.has_end = fire_end;
    bundle.cause   = cause;
    bundle.count   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= 64'd0;
      cnt_r       <= 16'd0;
      head_seen_r <= 1'b0;
      recv_r      <= 1'b0;
      idle_r      <= 24'd0;
    end else if (acc) begin
      recent_r    <= recent_nxt;
      cnt_r       <= cnt_nxt;
      head_seen_r <= head_seen_nxt;
      recv_r      <= recv_nxt;
      idle_r      <= idle_nxt;
    end
  end

`include "sentinel_packet_deframer_assert.svh"

  `SPD_ASSERT_NEXT(a_end_closes_packet, bundle.valid && bundle.has_end, !recv_r, "end item left packet open")
  `SPD_ASSERT_IMPLY(a_idle_silent, acc && !recv_r && (in_ch.command != spd_pkg::CMD_START), !bundle.valid, "result while idle")

endmodule
`default_nettype wire

// File: design/spd_emit.sv
`timescale 1ns / 1ps
`default_nettype none
module spd_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  spd_pkg::bundle_t bundle,
  output logic             take,
  spd_out_if.source        out_ch
);

  logic        valid_r;
  logic [63:0] data_r;
  logic [3:0]  n_r;
  logic        has_end_r;
  logic [1:0]  cause_r;
  logic [15:0] count_r;
  logic        is_end, is_last, fire;

  assign is_end  = (n_r == 4'd0);
  assign is_last = is_end || (n_r == 4'd1 && !has_end_r);
  assign fire    = out_ch.valid && out_ch.ready;
  assign take    = !valid_r || (out_ch.ready && is_last);

  assign out_ch.valid      = valid_r;
  assign out_ch.item_kind  = is_end ? spd_pkg::ITEM_END : spd_pkg::ITEM_DATA;
  assign out_ch.data_byte  = is_end ? 8'd0 : data_r[7:0];
  assign out_ch.end_cause  = is_end ? cause_r : spd_pkg::CAUSE_TAIL;
  assign out_ch.byte_count = is_end ? count_r : 16'd0;
  assign out_ch.last       = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      n_r       <= 4'd0;
      has_end_r <= 1'b0;
    end else if (bundle.valid) begin
      valid_r   <= 1'b1;
      n_r       <= bundle.n_data;
      has_end_r <= bundle.has_end;
    end else if (fire) begin
      if (is_last) valid_r <= 1'b0;
      if (!is_end) n_r <= n_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle.valid) begin
      data_r  <= bundle.data;
      cause_r <= bundle.cause;
      count_r <= bundle.count;
    end else if (fire && !is_end) begin
      // advance to the next held byte
      data_r <= {8'd0, data_r[63:8]};
    end
  end

`include "sentinel_packet_deframer_assert.svh"

  `SPD_ASSERT_IMPLY(a_end_pending, valid_r && (n_r == 4'd0), has_end_r, "empty result set")
  `SPD_ASSERT_IMPLY(a_byte_count_range, valid_r, n_r <= 4'd8, "too many held bytes")
  `SPD_ASSERT_NEXT(a_drop_after_last, fire && is_last && !bundle.valid, !valid_r, "result repeated")

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [1:0]  cause;
    logic [15:0] count;
    logic        last;
  } frame_item_t;

  typedef enum int {PH_STEADY, PH_TX_GAPS, PH_RX_STALLS, PH_BOTH} pace_t;

  class frame_scoreboard;
    spd_pkg::cfg_t regs;
    logic [63:0]   recent;
    logic [15:0]   count;
    logic          head_seen;
    logic          receiving;
    logic [23:0]   idle_ticks;
    frame_item_t   pending_items[$];
    frame_item_t   step_items[$];
    int            errors;

    function new();
      regs = '{head: 64'd0, tail: 64'd0, pat_len: 4'd1, use_head: 1'b0, use_tail: 1'b0,
               max_len: 16'd65535, timeout: 24'd1000};
      recent = '0;
      count = '0;
      head_seen = 1'b0;
      receiving = 1'b0;
      idle_ticks = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        spd_pkg::REG_HEAD:     regs.head = v;
        spd_pkg::REG_TAIL:     regs.tail = v;
        spd_pkg::REG_PAT_LEN:  regs.pat_len = v[3:0];
        spd_pkg::REG_USE_HEAD: regs.use_head = v[0];
        spd_pkg::REG_USE_TAIL: regs.use_tail = v[0];
        spd_pkg::REG_MAX_LEN:  regs.max_len = v[15:0];
        spd_pkg::REG_TIMEOUT:  regs.timeout = v[23:0];
        default: ;
      endcase
    endfunction

    function int unsigned sentinel_len();
      int unsigned n;
      n = regs.pat_len;
      if (n < 1) n = 1;
      if (n > spd_pkg::MAX_PATTERN_BYTES) n = spd_pkg::MAX_PATTERN_BYTES;
      return n;
    endfunction

    // Last n bytes, oldest in bits 7:0.
    function logic [63:0] window(int unsigned n);
      return recent >> (8 * (8 - n));
    endfunction

    function logic [63:0] byte_mask(int unsigned n);
      return n >= 8 ? {64{1'b1}} : ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function void push_item(logic kind, logic [7:0] data, logic [1:0] cause,
                            logic [15:0] cnt);
      step_items.push_back('{kind: kind, data: data, cause: cause, count: cnt, last: 1'b0});
    endfunction

    function void emit_window(int unsigned n);
      logic [63:0] w;
      if (n == 0 || n > 8) return;
      w = window(n);
      for (int unsigned i = 0; i < n; i++)
        push_item(spd_pkg::ITEM_DATA, w[8*i +: 8], spd_pkg::CAUSE_TAIL, 16'd0);
    endfunction

    function void close_packet(logic [1:0] cause);
      // flush head bytes still held unchecked
      if (regs.use_head && !head_seen && count < 8) emit_window(count);
      push_item(spd_pkg::ITEM_END, 8'd0, cause, count);
      receiving = 1'b0;
    endfunction

    function void take_request(logic [1:0] cmd, logic [7:0] b);
      int unsigned n;
      bit check_tail;
      n = sentinel_len();
      step_items.delete();
      if (cmd == spd_pkg::CMD_START) begin
        recent = '0;
        count = '0;
        head_seen = 1'b0;
        idle_ticks = '0;
        receiving = 1'b1;
        if (regs.max_len == 0) close_packet(spd_pkg::CAUSE_LENGTH);
      end else if (cmd == spd_pkg::CMD_BYTE && receiving) begin
        check_tail = 1'b1;
        idle_ticks = '0;
        recent = {b, recent[63:8]};
        if (count != 16'hFFFF) count++;
        if (regs.use_head && !head_seen) begin
          if (count >= n) begin
            if ((window(n) & byte_mask(n)) == (regs.head & byte_mask(n))) begin
              head_seen = 1'b1;
              emit_window(count < 8 ? count : n);
            end else begin
              count = '0;
              recent = '0;
              check_tail = 1'b0;
            end
          end else begin
            check_tail = 1'b0;
          end
        end else begin
          push_item(spd_pkg::ITEM_DATA, b, spd_pkg::CAUSE_TAIL, 16'd0);
        end
        if (check_tail && regs.use_tail && count >= n &&
            (window(n) & byte_mask(n)) == (regs.tail & byte_mask(n)))
          close_packet(spd_pkg::CAUSE_TAIL);
        else if (count >= regs.max_len)
          close_packet(spd_pkg::CAUSE_LENGTH);
      end else if (cmd == spd_pkg::CMD_TICK && receiving) begin
        if (idle_ticks != 24'hFFFFFF) idle_ticks++;
        if (idle_ticks >= regs.timeout) close_packet(spd_pkg::CAUSE_TIMEOUT);
      end
      if (step_items.size() > 0) step_items[step_items.size() - 1].last = 1'b1;
      foreach (step_items[i]) pending_items.push_back(step_items[i]);
    endfunction

    function void flag(string what, frame_item_t want, frame_item_t got);
      errors++;
      if (errors <= 10)
        $display({"%s: expected kind=%0d data=%02h cause=%0d count=%0d last=%0d,",
                  " got kind=%0d data=%02h cause=%0d count=%0d last=%0d"},
                 what, want.kind, want.data, want.cause, want.count, want.last,
                 got.kind, got.data, got.cause, got.count, got.last);
    endfunction

    function void check_item(frame_item_t got);
      frame_item_t want;
      if (pending_items.size() == 0) begin
        flag("unexpected result", '0, got);
        return;
      end
      want = pending_items.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.cause !== want.cause ||
          got.count !== want.count || got.last !== want.last)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();
  spd_cfg_if cfg_ch ();

  sentinel_packet_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard board;
  pace_t           tx_pace;
  pace_t           rx_pace;
  int              hold_cycles;
  int              sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin : watch
    frame_item_t seen;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) board.write_reg(cfg_ch.index, cfg_ch.wdata);
      if (in_ch.valid && in_ch.ready) board.take_request(in_ch.command, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen = '{kind: out_ch.item_kind, data: out_ch.data_byte, cause: out_ch.end_cause,
                 count: out_ch.byte_count, last: out_ch.last};
        board.check_item(seen);
      end
    end
  end

  function automatic bit rx_stall();
    case (rx_pace)
      PH_RX_STALLS: return $urandom_range(99) < 54;
      PH_BOTH:      return $urandom_range(99) < 14;
      default:      return 1'b0;
    endcase
  endfunction

  function automatic bit tx_gap();
    case (tx_pace)
      PH_TX_GAPS: return $urandom_range(99) < 54;
      PH_BOTH:    return $urandom_range(99) < 14;
      default:    return 1'b0;
    endcase
  endfunction

  // result side: long hold-off first, then random stalls by phase
  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles = hold_cycles - 1;
    out_ch.ready = (hold_cycles == 0) && !rx_stall();
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] b);
    while (tx_gap()) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Drain all expected results, then let the pipeline go quiet.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (board.pending_items.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.wdata = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_setting(input spd_pkg::cfg_t c);
    settle();
    write_reg(spd_pkg::REG_HEAD, c.head);
    write_reg(spd_pkg::REG_TAIL, c.tail);
    write_reg(spd_pkg::REG_PAT_LEN, {60'd0, c.pat_len});
    write_reg(spd_pkg::REG_USE_HEAD, {63'd0, c.use_head});
    write_reg(spd_pkg::REG_USE_TAIL, {63'd0, c.use_tail});
    write_reg(spd_pkg::REG_MAX_LEN, {48'd0, c.max_len});
    write_reg(spd_pkg::REG_TIMEOUT, {40'd0, c.timeout});
    cfg_ch.valid = 1'b0;
  endtask

  function automatic spd_pkg::cfg_t random_setting();
    spd_pkg::cfg_t c;
    c.head = {$urandom, $urandom};
    c.tail = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       c.pat_len = 4'd0;
      1:       c.pat_len = 4'($urandom_range(15, 9));
      default: c.pat_len = 4'($urandom_range(8, 1));
    endcase
    c.use_head = 1'($urandom_range(1));
    c.use_tail = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       c.max_len = 16'd0;
      1:       c.max_len = 16'hFFFF;
      default: c.max_len = 16'($urandom_range(24, 1));
    endcase
    case ($urandom_range(9))
      0:       c.timeout = 24'd0;
      1:       c.timeout = 24'hFFFFFF;
      default: c.timeout = 24'($urandom_range(8, 1));
    endcase
    return c;
  endfunction

  // One packet: start, optional noise and head, payload with ticks, optional tail.
  task automatic send_packet();
    int unsigned plen;
    int unsigned len;
    logic [63:0] head;
    logic [63:0] tail;
    plen = board.regs.pat_len == 0 ? 1 :
           (board.regs.pat_len > spd_pkg::MAX_PATTERN_BYTES ?
            spd_pkg::MAX_PATTERN_BYTES : board.regs.pat_len);
    head = board.regs.head;
    tail = board.regs.tail;
    send_request(spd_pkg::CMD_START, 8'($urandom_range(255)));
    if (board.regs.use_head) begin
      // a full window of noise keeps the real head aligned after the mismatch
      if ($urandom_range(3) == 0)
        for (int unsigned i = 0; i < plen; i++)
          send_request(spd_pkg::CMD_BYTE, 8'($urandom_range(255)));
      if ($urandom_range(4) != 0)
        for (int unsigned i = 0; i < plen; i++) send_request(spd_pkg::CMD_BYTE, head[8*i +: 8]);
    end
    len = $urandom_range(12);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0, 1:    send_request(spd_pkg::CMD_TICK, 8'($urandom_range(255)));
        2:       send_request(2'($urandom_range(3)), 8'($urandom_range(255)));
        default: send_request(spd_pkg::CMD_BYTE, 8'($urandom_range(255)));
      endcase
    end
    if (board.regs.use_tail && $urandom_range(1))
      for (int unsigned i = 0; i < plen; i++) send_request(spd_pkg::CMD_BYTE, tail[8*i +: 8]);
    len = $urandom_range(3);
    for (int unsigned i = 0; i < len; i++)
      send_request(spd_pkg::CMD_TICK, 8'($urandom_range(255)));
  endtask

  initial begin
    spd_pkg::cfg_t setting;
    int            quota;
    board = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = spd_pkg::CMD_TICK;
    in_ch.rx_byte = 8'd0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = spd_pkg::REG_HEAD;
    cfg_ch.wdata = 64'd0;
    tx_pace = PH_STEADY;
    rx_pace = PH_STEADY;
    hold_cycles = 0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset setting: idle requests and the unused command are dropped
    send_request(spd_pkg::CMD_BYTE, 8'h00);
    send_request(spd_pkg::CMD_TICK, 8'hFF);
    send_request(2'd3, 8'h5A);
    send_request(spd_pkg::CMD_START, 8'h00);
    send_request(spd_pkg::CMD_BYTE, 8'h00);
    send_request(spd_pkg::CMD_BYTE, 8'hFF);
    send_request(2'd3, 8'hA5);
    send_request(spd_pkg::CMD_START, 8'hFF);
    send_request(spd_pkg::CMD_BYTE, 8'hA5);

    // head mismatch, head match, tail and length together, end while head held
    setting = '{head: 64'hBBAA, tail: 64'hDDCC, pat_len: 4'd2, use_head: 1'b1,
                use_tail: 1'b1, max_len: 16'd4, timeout: 24'd0};
    load_setting(setting);
    send_request(spd_pkg::CMD_START, 8'h00);
    send_request(spd_pkg::CMD_BYTE, 8'h11);
    send_request(spd_pkg::CMD_BYTE, 8'h22);
    send_request(spd_pkg::CMD_BYTE, 8'hAA);
    send_request(spd_pkg::CMD_BYTE, 8'hBB);
    send_request(spd_pkg::CMD_BYTE, 8'hCC);
    send_request(spd_pkg::CMD_BYTE, 8'hDD);
    send_request(spd_pkg::CMD_START, 8'h00);
    send_request(spd_pkg::CMD_BYTE, 8'hAA);
    send_request(spd_pkg::CMD_TICK, 8'h00);
    send_request(spd_pkg::CMD_START, 8'h00);
    send_request(spd_pkg::CMD_TICK, 8'h00);

    // zero pattern length; head and tail complete on one byte
    setting = '{head: 64'h5A, tail: 64'h5A, pat_len: 4'd0, use_head: 1'b1,
                use_tail: 1'b1, max_len: 16'hFFFF, timeout: 24'hFFFFFF};
    load_setting(setting);
    send_request(spd_pkg::CMD_START, 8'h00);
    send_request(spd_pkg::CMD_BYTE, 8'h5A);

    // zero max length ends at the start
    setting.max_len = 16'd0;
    load_setting(setting);
    send_request(spd_pkg::CMD_START, 8'h00);
    send_request(spd_pkg::CMD_BYTE, 8'h01);

    quota = sent;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: setting = '{head: {64{1'b1}}, tail: 64'd0, pat_len: 4'd15, use_head: 1'b1,
                       use_tail: 1'b1, max_len: 16'hFFFF, timeout: 24'hFFFFFF};
        1: setting = '{head: 64'd0, tail: {64{1'b1}}, pat_len: 4'd1, use_head: 1'b0,
                       use_tail: 1'b1, max_len: 16'd1, timeout: 24'd0};
        default: setting = random_setting();
      endcase
      load_setting(setting);
      tx_pace = pace_t'(p % 4);
      rx_pace = pace_t'(p % 4);
      if (p == 4) begin
        // hold the result side while the sender keeps pushing
        @(posedge clk);
        hold_cycles = 150;
        @(negedge clk);
      end
      quota += 26;
      while (sent < quota) send_packet();
    end

    rx_pace = PH_STEADY;
    tx_pace = PH_STEADY;
    in_ch.valid = 1'b0;
    while (board.pending_items.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
